### sv/ptc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptc_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SKIP = 2'd1;
    localparam logic [1:0] ST_ZDIV = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_TEMP    = 2'd0;
    localparam logic [1:0] REG_PRESS_A = 2'd1;
    localparam logic [1:0] REG_PRESS_B = 2'd2;
    localparam logic [1:0] REG_PRESS_9 = 2'd3;

    localparam logic [23:0]        SKIP_MARKER  = 24'h800000;
    localparam logic signed [25:0] TFINE_OFS    = 26'sd128000;
    localparam logic [20:0]        P_BASE       = 21'd1048576;
    localparam logic [11:0]        P_SCALE      = 12'd3125;
    // ceil(2^32 / 100), exact for magnitudes below 2^30
    localparam logic [25:0]        DIV100_RECIP = 26'd42949673;
    localparam logic [63:0]        W_BIAS       = 64'h0000_8000_0000_0000;

    // One quotient bit per divider stage
    localparam int DIV_STAGES = 64;

    // Per-item data that rides along the pressure path
    typedef struct packed {
        logic               marker;
        logic               zdiv;
        logic signed [23:0] tc;
        logic signed [17:0] deg;
    } t_side;

endpackage

`default_nettype wire

### sv/ptc_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider: 64-bit magnitude by 31-bit magnitude,
// one quotient bit per stage, sign applied in a final stage.
module ptc_div
    import ptc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_vld,
    input  wire t_side       i_side,
    input  wire logic [63:0] i_num,
    input  wire logic [30:0] i_den,
    input  wire logic        i_qneg,
    output logic             o_vld,
    output t_side            o_side,
    output logic [63:0]      o_quot
);

    logic        r_vld  [DIV_STAGES];
    t_side       r_side [DIV_STAGES];
    logic [31:0] r_rem  [DIV_STAGES];
    logic [63:0] r_sh   [DIV_STAGES];
    logic [30:0] r_den  [DIV_STAGES];
    logic        r_qneg [DIV_STAGES];

    logic        w_vld_in  [DIV_STAGES];
    t_side       w_side_in [DIV_STAGES];
    logic [31:0] w_rem_in  [DIV_STAGES];
    logic [63:0] w_sh_in   [DIV_STAGES];
    logic [30:0] w_den_in  [DIV_STAGES];
    logic        w_qneg_in [DIV_STAGES];

    logic [31:0] n_rem [DIV_STAGES];
    logic [63:0] n_sh  [DIV_STAGES];

    logic        r_ovld;
    t_side       r_oside;
    logic [63:0] r_quot;

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++) begin : g_src
            if (g == 0) begin : g_first
                assign w_vld_in[g]  = i_vld;
                assign w_side_in[g] = i_side;
                assign w_rem_in[g]  = '0;
                assign w_sh_in[g]   = i_num;
                assign w_den_in[g]  = i_den;
                assign w_qneg_in[g] = i_qneg;
            end else begin : g_rest
                assign w_vld_in[g]  = r_vld[g-1];
                assign w_side_in[g] = r_side[g-1];
                assign w_rem_in[g]  = r_rem[g-1];
                assign w_sh_in[g]   = r_sh[g-1];
                assign w_den_in[g]  = r_den[g-1];
                assign w_qneg_in[g] = r_qneg[g-1];
            end
        end
    endgenerate

    always_comb begin
        logic [31:0] t;
        logic        ge;
        for (int k = 0; k < DIV_STAGES; k++) begin
            t  = {w_rem_in[k][30:0], w_sh_in[k][63]};
            ge = (t >= {1'b0, w_den_in[k]});
            n_rem[k] = ge ? (t - {1'b0, w_den_in[k]}) : t;
            n_sh[k]  = {w_sh_in[k][62:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_ovld <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_vld[k] <= w_vld_in[k];
            end
            r_ovld <= r_vld[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_side[k] <= w_side_in[k];
                r_rem[k]  <= n_rem[k];
                r_sh[k]   <= n_sh[k];
                r_den[k]  <= w_den_in[k];
                r_qneg[k] <= w_qneg_in[k];
            end
            r_oside <= r_side[DIV_STAGES-1];
            r_quot  <= r_qneg[DIV_STAGES-1] ? (~r_sh[DIV_STAGES-1] + 64'd1)
                                            : r_sh[DIV_STAGES-1];
        end
    end

    assign o_vld  = r_ovld;
    assign o_side = r_oside;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

### sv/pressure_temperature_compensation_top.sv
// Throughput: one item per cycle unless i_stall holds a finished result;
// the 64-stage divider sets the depth.
// The input has a one-item skid slot, so o_stall is registered and one item
// is still taken while a finished result waits on i_stall.
// Reset (i_rst_n low, synchronous) empties the pipeline and clears all
// coefficient registers to zero.
`timescale 1ns / 1ps
`default_nettype none

module pressure_temperature_compensation_top
    import ptc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [23:0] i_pressure_raw,
    input  wire logic [23:0] i_temperature_raw,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [23:0]      o_temperature_centi,
    output logic [17:0]      o_temperature_deg,
    output logic [31:0]      o_pressure_q8,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);

    // ---------------------------------------------------------------
    // Coefficient registers (the user must write them only while the block is idle; the block does not enforce it)
    // ---------------------------------------------------------------
    logic [47:0] r_temp;
    logic [63:0] r_pa;
    logic [63:0] r_pb;
    logic [15:0] r_p9;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp <= '0;
            r_pa   <= '0;
            r_pb   <= '0;
            r_p9   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TEMP:    r_temp <= i_cfg_data[47:0];
                REG_PRESS_A: r_pa   <= i_cfg_data;
                REG_PRESS_B: r_pb   <= i_cfg_data;
                REG_PRESS_9: r_p9   <= i_cfg_data[15:0];
                default:     r_p9   <= r_p9;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    logic [15:0]        w_t1, w_p1;
    logic signed [15:0] w_t2, w_t3, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;

    assign w_t1 = r_temp[15:0];
    assign w_t2 = r_temp[31:16];
    assign w_t3 = r_temp[47:32];
    assign w_p1 = r_pa[15:0];
    assign w_p2 = r_pa[31:16];
    assign w_p3 = r_pa[47:32];
    assign w_p4 = r_pa[63:48];
    assign w_p5 = r_pb[15:0];
    assign w_p6 = r_pb[31:16];
    assign w_p7 = r_pb[47:32];
    assign w_p8 = r_pb[63:48];
    assign w_p9 = r_p9;

    // ---------------------------------------------------------------
    // Flow control: one global advance, skid slot on the input
    // ---------------------------------------------------------------
    logic        w_en;
    logic        w_in_acc;
    logic        r_skid_vld;
    logic [23:0] r_skid_p, r_skid_t;
    logic [10:0] r_sv;      // valid bits of stages S1..S11
    logic [4:0]  r_pv;      // valid bits of stages P1..P5
    logic        w_dv;

    assign w_en     = !r_pv[4] || !i_stall;
    assign w_in_acc = i_valid && !r_skid_vld;
    assign o_stall  = r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
            r_sv       <= '0;
            r_pv       <= '0;
        end else begin
            if (w_en) begin
                r_skid_vld <= 1'b0;
                r_sv       <= {r_sv[9:0], r_skid_vld || i_valid};
                r_pv       <= {r_pv[3:0], w_dv};
            end else if (w_in_acc) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_en && w_in_acc) begin
            r_skid_p <= i_pressure_raw;
            r_skid_t <= i_temperature_raw;
        end
    end

    logic [23:0] w_src_p, w_src_t;
    assign w_src_p = r_skid_vld ? r_skid_p : i_pressure_raw;
    assign w_src_t = r_skid_vld ? r_skid_t : i_temperature_raw;

    // ---------------------------------------------------------------
    // S1: marker check, 20-bit samples, first differences
    // ---------------------------------------------------------------
    logic               r_s1_mk;
    logic signed [17:0] r_s1_at;
    logic signed [16:0] r_s1_d;
    logic [20:0]        r_s1_xp;

    logic [19:0]        w_adc_t, w_adc_p;
    logic signed [17:0] w_at;
    logic signed [16:0] w_d;
    assign w_adc_t = w_src_t[23:4];
    assign w_adc_p = w_src_p[23:4];
    assign w_at    = $signed({1'b0, w_adc_t[19:3]}) - $signed({1'b0, w_t1, 1'b0});
    assign w_d     = $signed({1'b0, w_adc_t[19:4]}) - $signed({1'b0, w_t1});

    // S2: temperature products
    logic               r_s2_mk;
    logic signed [33:0] r_s2_m1, r_s2_dd;
    logic [20:0]        r_s2_xp;
    logic signed [33:0] w_m1, w_dd;
    assign w_m1 = r_s1_at * w_t2;
    assign w_dd = r_s1_d * r_s1_d;

    // S3: scaled terms, second temperature product
    logic               r_s3_mk;
    logic signed [22:0] r_s3_v1;
    logic signed [37:0] r_s3_m2;
    logic [20:0]        r_s3_xp;
    logic signed [21:0] w_dd12;
    logic signed [37:0] w_m2;
    assign w_dd12 = r_s2_dd[33:12];
    assign w_m2   = w_dd12 * w_t3;

    // S4: fine temperature
    logic               r_s4_mk;
    logic signed [24:0] r_s4_tf;
    logic [20:0]        r_s4_xp;
    logic signed [23:0] w_m2s;
    logic signed [24:0] w_tf;
    assign w_m2s = r_s3_m2[37:14];
    assign w_tf  = r_s3_v1 + w_m2s;

    // S5: centi-degrees and pressure offset term
    // (the 21-bit centi value cannot leave the 24-bit range, so sign
    // extension is the saturation)
    t_side              r_s5_sd;
    logic signed [25:0] r_s5_x;
    logic [20:0]        r_s5_xp;
    logic signed [28:0] w_t5;
    logic signed [23:0] w_tc;
    logic signed [25:0] w_x;
    assign w_t5 = r_s4_tf * 29'sd5 + 29'sd128;
    assign w_tc = {{3{w_t5[28]}}, w_t5[28:8]};
    assign w_x  = r_s4_tf - TFINE_OFS;

    // S6: squares and linear terms, divide-by-100 product
    t_side              r_s6_sd;
    logic [49:0]        r_s6_tprod;
    logic               r_s6_tneg;
    logic signed [51:0] r_s6_xx;
    logic signed [41:0] r_s6_xp2, r_s6_xp5;
    logic [20:0]        r_s6_xp;
    logic [23:0]        w_tmag;
    logic signed [51:0] w_xx;
    logic signed [41:0] w_xp2, w_xp5;
    assign w_tmag = r_s5_sd.tc[23] ? (~r_s5_sd.tc + 24'd1) : r_s5_sd.tc;
    assign w_xx   = r_s5_x * r_s5_x;
    assign w_xp2  = r_s5_x * w_p2;
    assign w_xp5  = r_s5_x * w_p5;

    // S7: quadratic terms (mod 2^64), whole degrees
    t_side              r_s7_sd;
    logic [63:0]        r_s7_a6, r_s7_a3;
    logic signed [41:0] r_s7_xp2, r_s7_xp5;
    logic [20:0]        r_s7_xp;
    logic signed [67:0] w_a6, w_a3;
    logic [17:0]        w_dmag;
    assign w_a6   = r_s6_xx * w_p6;
    assign w_a3   = r_s6_xx * w_p3;
    assign w_dmag = r_s6_tprod[49:32];

    // S8: v2 and the divisor seed
    t_side       r_s8_sd;
    logic [63:0] r_s8_v2, r_s8_w;
    logic [20:0] r_s8_xp;
    logic [63:0] w_v2, w_a3s, w_v1a;
    assign w_v2  = r_s7_a6 + ({{22{r_s7_xp5[41]}}, r_s7_xp5} << 17)
                 + ({{48{w_p4[15]}}, w_p4} << 35);
    assign w_a3s = $signed(r_s7_a3) >>> 8;
    assign w_v1a = w_a3s + ({{22{r_s7_xp2[41]}}, r_s7_xp2} << 12);

    // S9: numerator base, divisor partial products
    t_side       r_s9_sd;
    logic [63:0] r_s9_num;
    logic [47:0] r_s9_wl;
    logic [31:0] r_s9_wh;
    logic [47:0] w_wl, w_whf;
    assign w_wl  = r_s8_w[31:0] * w_p1;
    assign w_whf = r_s8_w[63:32] * w_p1;

    // S10: divisor, numerator partial products
    t_side              r_s10_sd;
    logic signed [30:0] r_s10_den;
    logic [43:0]        r_s10_nl;
    logic [31:0]        r_s10_nh;
    logic [63:0]        w_wprod;
    logic [43:0]        w_nl, w_nhf;
    assign w_wprod = {16'd0, r_s9_wl} + {r_s9_wh, 32'd0};
    assign w_nl    = r_s9_num[31:0] * P_SCALE;
    assign w_nhf   = r_s9_num[63:32] * P_SCALE;

    // S11: signed operands to magnitudes for the divider
    t_side       r_s11_sd;
    logic [63:0] r_s11_nmag;
    logic [30:0] r_s11_dmag;
    logic        r_s11_qneg;
    logic [63:0] w_num;
    assign w_num = {20'd0, r_s10_nl} + {r_s10_nh, 32'd0};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // S1
            r_s1_mk <= (w_src_p == SKIP_MARKER) || (w_src_t == SKIP_MARKER);
            r_s1_at <= w_at;
            r_s1_d  <= w_d;
            r_s1_xp <= P_BASE - {1'b0, w_adc_p};
            // S2
            r_s2_mk <= r_s1_mk;
            r_s2_m1 <= w_m1;
            r_s2_dd <= w_dd;
            r_s2_xp <= r_s1_xp;
            // S3
            r_s3_mk <= r_s2_mk;
            r_s3_v1 <= r_s2_m1[33:11];
            r_s3_m2 <= w_m2;
            r_s3_xp <= r_s2_xp;
            // S4
            r_s4_mk <= r_s3_mk;
            r_s4_tf <= w_tf;
            r_s4_xp <= r_s3_xp;
            // S5
            r_s5_sd <= '{marker: r_s4_mk, zdiv: 1'b0, tc: w_tc, deg: '0};
            r_s5_x  <= w_x;
            r_s5_xp <= r_s4_xp;
            // S6
            r_s6_sd    <= r_s5_sd;
            r_s6_tprod <= w_tmag * DIV100_RECIP;
            r_s6_tneg  <= r_s5_sd.tc[23];
            r_s6_xx    <= w_xx;
            r_s6_xp2   <= w_xp2;
            r_s6_xp5   <= w_xp5;
            r_s6_xp    <= r_s5_xp;
            // S7
            r_s7_sd  <= '{marker: r_s6_sd.marker,
                          zdiv:   r_s6_sd.zdiv,
                          tc:     r_s6_sd.tc,
                          deg:    r_s6_tneg ? (~w_dmag + 18'd1) : w_dmag};
            r_s7_a6  <= w_a6[63:0];
            r_s7_a3  <= w_a3[63:0];
            r_s7_xp2 <= r_s6_xp2;
            r_s7_xp5 <= r_s6_xp5;
            r_s7_xp  <= r_s6_xp;
            // S8
            r_s8_sd <= r_s7_sd;
            r_s8_v2 <= w_v2;
            r_s8_w  <= w_v1a + W_BIAS;
            r_s8_xp <= r_s7_xp;
            // S9
            r_s9_sd  <= r_s8_sd;
            r_s9_num <= ({43'd0, r_s8_xp} << 31) - r_s8_v2;
            r_s9_wl  <= w_wl;
            r_s9_wh  <= w_whf[31:0];
            // S10
            r_s10_sd  <= r_s9_sd;
            r_s10_den <= w_wprod[63:33];
            r_s10_nl  <= w_nl;
            r_s10_nh  <= w_nhf[31:0];
            // S11
            r_s11_sd   <= '{marker: r_s10_sd.marker,
                            zdiv:   (r_s10_den == '0),
                            tc:     r_s10_sd.tc,
                            deg:    r_s10_sd.deg};
            r_s11_nmag <= w_num[63] ? (~w_num + 64'd1) : w_num;
            r_s11_dmag <= r_s10_den[30] ? (~r_s10_den + 31'd1) : r_s10_den;
            r_s11_qneg <= w_num[63] ^ r_s10_den[30];
        end
    end

    // ---------------------------------------------------------------
    // Divider: 64 stages plus sign stage
    // ---------------------------------------------------------------
    t_side       w_dside;
    logic [63:0] w_q;

    ptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_sv[10]),
        .i_side  (r_s11_sd),
        .i_num   (r_s11_nmag),
        .i_den   (r_s11_dmag),
        .i_qneg  (r_s11_qneg),
        .o_vld   (w_dv),
        .o_side  (w_dside),
        .o_quot  (w_q)
    );

    // ---------------------------------------------------------------
    // P1..P5: correction terms, all mod 2^64, split into 32-bit halves
    // ---------------------------------------------------------------
    // P1: h*h and p*P8 partial products
    t_side              r_p1_sd;
    logic [63:0]        r_p1_p, r_p1_ll;
    logic [31:0]        r_p1_lh, r_p1_bh;
    logic signed [48:0] r_p1_bl;
    logic [63:0]        w_h, w_lhf, w_bhf;
    logic signed [48:0] w_bl;
    assign w_h   = $signed(w_q) >>> 13;
    assign w_lhf = w_h[31:0] * w_h[63:32];
    assign w_bl  = $signed({1'b0, w_q[31:0]}) * w_p8;
    assign w_bhf = w_q[63:32] * {{16{w_p8[15]}}, w_p8};

    // P2: sum halves
    t_side       r_p2_sd;
    logic [63:0] r_p2_p, r_p2_hs, r_p2_b;

    // P3: P9 * h^2 partials, shifted P8 term
    t_side              r_p3_sd;
    logic [63:0]        r_p3_p, r_p3_b19;
    logic signed [48:0] r_p3_al;
    logic [31:0]        r_p3_ah;
    logic signed [48:0] w_al;
    logic [63:0]        w_ahf, w_b19;
    assign w_al  = $signed({1'b0, r_p2_hs[31:0]}) * w_p9;
    assign w_ahf = r_p2_hs[63:32] * {{16{w_p9[15]}}, w_p9};
    assign w_b19 = $signed(r_p2_b) >>> 19;

    // P4: p + a + b
    t_side       r_p4_sd;
    logic [63:0] r_p4_s;
    logic [63:0] w_aprod, w_a;
    assign w_aprod = {{15{r_p3_al[48]}}, r_p3_al} + {r_p3_ah, 32'd0};
    assign w_a     = $signed(w_aprod) >>> 25;

    // P5: final offset, clamp, output register
    logic [63:0] w_s8, w_pf;
    logic [31:0] w_pclamp;
    assign w_s8 = $signed(r_p4_s) >>> 8;
    assign w_pf = w_s8 + ({{48{w_p7[15]}}, w_p7} << 4);

    always_comb begin
        if (w_pf[63]) begin
            w_pclamp = '0;
        end else if (|w_pf[62:32]) begin
            w_pclamp = '1;
        end else begin
            w_pclamp = w_pf[31:0];
        end
    end

    logic [1:0]  r_out_status;
    logic [23:0] r_out_tc;
    logic [17:0] r_out_deg;
    logic [31:0] r_out_pq;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_sd <= w_dside;
            r_p1_p  <= w_q;
            r_p1_ll <= w_h[31:0] * w_h[31:0];
            r_p1_lh <= w_lhf[31:0];
            r_p1_bl <= w_bl;
            r_p1_bh <= w_bhf[31:0];

            r_p2_sd <= r_p1_sd;
            r_p2_p  <= r_p1_p;
            r_p2_hs <= r_p1_ll + {r_p1_lh[30:0], 33'd0};
            r_p2_b  <= {{15{r_p1_bl[48]}}, r_p1_bl} + {r_p1_bh, 32'd0};

            r_p3_sd  <= r_p2_sd;
            r_p3_p   <= r_p2_p;
            r_p3_b19 <= w_b19;
            r_p3_al  <= w_al;
            r_p3_ah  <= w_ahf[31:0];

            r_p4_sd <= r_p3_sd;
            r_p4_s  <= r_p3_p + w_a + r_p3_b19;

            if (r_p4_sd.marker) begin
                r_out_status <= ST_SKIP;
                r_out_tc     <= '0;
                r_out_deg    <= '0;
                r_out_pq     <= '0;
            end else if (r_p4_sd.zdiv) begin
                r_out_status <= ST_ZDIV;
                r_out_tc     <= r_p4_sd.tc;
                r_out_deg    <= r_p4_sd.deg;
                r_out_pq     <= '0;
            end else begin
                r_out_status <= ST_OK;
                r_out_tc     <= r_p4_sd.tc;
                r_out_deg    <= r_p4_sd.deg;
                r_out_pq     <= w_pclamp;
            end
        end
    end

    assign o_valid             = r_pv[4];
    assign o_status            = r_out_status;
    assign o_temperature_centi = r_out_tc;
    assign o_temperature_deg   = r_out_deg;
    assign o_pressure_q8       = r_out_pq;

`ifndef SYNTHESIS
    // Skid slot always drains on an advance
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && w_en) |=> !r_skid_vld)
        else $error("skid slot not drained");

    // Only defined status codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_status == ST_OK) || (o_status == ST_SKIP) || (o_status == ST_ZDIV)))
        else $error("undefined status code");

    // A skipped measurement carries all-zero fields
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_SKIP)) |->
        ((o_pressure_q8 == '0) && (o_temperature_centi == '0) && (o_temperature_deg == '0)))
        else $error("skipped item has nonzero fields");

    // Zero divisor yields zero pressure
    a_zdiv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_ZDIV)) |-> (o_pressure_q8 == '0))
        else $error("zero divisor item has nonzero pressure");
`endif

endmodule

`default_nettype wire
